[hdl/nss_pkg.sv]
// nss_pkg: shared constants, register codes and width helpers for the nine-slice splitter
// no dependencies; every other file of the block refers to it by scoped names
package nss_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int IMAGE_DIM_WIDTH     = 11;
   localparam int FRAC_BITS           = 4;
   localparam int NUM_SLICES          = 9;
   localparam int NUM_COLS            = 3;
   localparam int SLICE_IDX_WIDTH     = 4;
   localparam int FRONT_STAGES        = 6;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int CSR_ADDR_WIDTH      = 5;
   localparam int CSR_INDEX_LSB       = 2;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_INSET_LEFT   = 3'd2,
      REG_INSET_TOP    = 3'd3,
      REG_INSET_RIGHT  = 3'd4,
      REG_INSET_BOTTOM = 3'd5
   } reg_index_type;

   // width of a source or destination span
   function automatic int span_width(int coord_width);
      int img_span;
      img_span = IMAGE_DIM_WIDTH + FRAC_BITS;
      return (coord_width - 1 > img_span) ? coord_width - 1 : img_span;
   endfunction

   // width that holds a position plus an offset without wrapping
   function automatic int sum_width(int coord_width);
      int sw;
      sw = span_width(coord_width);
      return ((coord_width > sw + 2) ? coord_width : sw + 2) + 1;
   endfunction

   function automatic int axis_plan_width(int coord_width);
      int sw;
      sw = span_width(coord_width);
      return 2 * coord_width + 4 * sw + 2 * (sw + 1);
   endfunction

   function automatic int plan_width(int coord_width);
      return NUM_SLICES + 2 * axis_plan_width(coord_width);
   endfunction

endpackage

[hdl/nss_req_if.sv]
// nss_req_if: request channel carrying one draw (destination and optional source rect)
// depends on nss_pkg for the default coordinate width
interface nss_req_if #(
   parameter int COORD_WIDTH = nss_pkg::COORD_WIDTH_DEFAULT
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] dest_x;
   logic signed [COORD_WIDTH-1:0] dest_y;
   logic        [COORD_WIDTH-2:0] dest_w;
   logic        [COORD_WIDTH-2:0] dest_h;
   logic                          use_source_rect;
   logic signed [COORD_WIDTH-1:0] source_x;
   logic signed [COORD_WIDTH-1:0] source_y;
   logic        [COORD_WIDTH-2:0] source_w;
   logic        [COORD_WIDTH-2:0] source_h;

   modport source (
      output valid, dest_x, dest_y, dest_w, dest_h, use_source_rect,
             source_x, source_y, source_w, source_h,
      input  ready
   );

   modport sink (
      input  valid, dest_x, dest_y, dest_w, dest_h, use_source_rect,
             source_x, source_y, source_w, source_h,
      output ready
   );
endinterface

[hdl/nss_rsp_if.sv]
// nss_rsp_if: response channel carrying one slice per beat
// depends on nss_pkg for the default coordinate width and slice index width
interface nss_rsp_if #(
   parameter int COORD_WIDTH = nss_pkg::COORD_WIDTH_DEFAULT
) ();
   logic                                      valid;
   logic                                      ready;
   logic        [nss_pkg::SLICE_IDX_WIDTH-1:0] slice_index;
   logic signed [COORD_WIDTH+1:0]              out_dst_x;
   logic signed [COORD_WIDTH+1:0]              out_dst_y;
   logic        [COORD_WIDTH-1:0]              out_dst_w;
   logic        [COORD_WIDTH-1:0]              out_dst_h;
   logic signed [COORD_WIDTH+1:0]              out_src_x;
   logic signed [COORD_WIDTH+1:0]              out_src_y;
   logic        [COORD_WIDTH-1:0]              out_src_w;
   logic        [COORD_WIDTH-1:0]              out_src_h;
   logic                                      last_slice;

   modport source (
      output valid, slice_index, out_dst_x, out_dst_y, out_dst_w, out_dst_h,
             out_src_x, out_src_y, out_src_w, out_src_h, last_slice,
      input  ready
   );

   modport sink (
      input  valid, slice_index, out_dst_x, out_dst_y, out_dst_w, out_dst_h,
             out_src_x, out_src_y, out_src_w, out_src_h, last_slice,
      output ready
   );
endinterface

[hdl/nss_axis.sv]
// nss_axis: pipelined inset clamp and span split for one axis (lead, middle, trail)
// depends on nss_pkg; instanced twice by nss_front, advances on a shared enable
module nss_axis #(
   parameter int COORD_WIDTH = nss_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           en,
   input  logic [COORD_WIDTH-1:0]                         d_pos,
   input  logic [nss_pkg::span_width(COORD_WIDTH)-1:0]    d_len,
   input  logic [COORD_WIDTH-1:0]                         s_pos,
   input  logic [nss_pkg::span_width(COORD_WIDTH)-1:0]    s_len,
   input  logic [nss_pkg::span_width(COORD_WIDTH)-1:0]    lead_ins,
   input  logic [nss_pkg::span_width(COORD_WIDTH)-1:0]    trail_ins,
   output logic [COORD_WIDTH-1:0]                         pos_d,
   output logic [COORD_WIDTH-1:0]                         pos_s,
   output logic [nss_pkg::span_width(COORD_WIDTH)-1:0]    lead,
   output logic [nss_pkg::span_width(COORD_WIDTH)-1:0]    mid_d,
   output logic [nss_pkg::span_width(COORD_WIDTH)-1:0]    mid_s,
   output logic [nss_pkg::span_width(COORD_WIDTH)-1:0]    trail,
   output logic [nss_pkg::span_width(COORD_WIDTH):0]      off_d,
   output logic [nss_pkg::span_width(COORD_WIDTH):0]      off_s,
   output logic [nss_pkg::NUM_COLS-1:0]                   band_ok
);
   localparam int W  = COORD_WIDTH;
   localparam int SW = nss_pkg::span_width(COORD_WIDTH);
   localparam int ST = nss_pkg::FRONT_STAGES;

   logic [W-1:0]  dpos_ff [ST];
   logic [W-1:0]  spos_ff [ST];

   logic [SW-1:0] dlen1_ff, slen1_ff;
   logic [SW-1:0] dlen2_ff, slen2_ff, lead2_ff, lead2_in;
   logic [SW-1:0] lead3_ff, rem3_ff, rem3_in;
   logic [SW:0]   dwl3_ff, dwl3_in;
   logic [SW-1:0] lead4_ff, rem4_ff, trail4_ff, trail4_in;
   logic [SW:0]   dwl4_ff;
   logic [SW+1:0] diff5;
   logic [SW-1:0] lead5_ff, trail5_ff, mid_d5_ff, mid_d5_in, mid_s5_ff, mid_s5_in;
   logic [SW-1:0] lead6_ff, trail6_ff, mid_d6_ff, mid_s6_ff;
   logic [SW:0]   off_d6_ff, off_d6_in, off_s6_ff, off_s6_in;

   always_comb begin
      lead2_in  = (lead_ins > slen1_ff) ? slen1_ff : lead_ins;
      rem3_in   = slen2_ff - lead2_ff;
      dwl3_in   = (SW+1)'(dlen2_ff) - (SW+1)'(lead2_ff);
      trail4_in = (trail_ins > rem3_ff) ? rem3_ff : trail_ins;
      diff5     = (SW+2)'($signed(dwl4_ff)) - (SW+2)'(trail4_ff);
      mid_d5_in = diff5[SW+1] ? '0 : diff5[SW-1:0];
      mid_s5_in = rem4_ff - trail4_ff;
      off_d6_in = (SW+1)'(lead5_ff) + (SW+1)'(mid_d5_ff);
      off_s6_in = (SW+1)'(lead5_ff) + (SW+1)'(mid_s5_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dpos_ff[0] <= d_pos;
         spos_ff[0] <= s_pos;
         for (int i = 1; i < ST; i++) begin
            dpos_ff[i] <= dpos_ff[i-1];
            spos_ff[i] <= spos_ff[i-1];
         end
         dlen1_ff  <= d_len;
         slen1_ff  <= s_len;
         dlen2_ff  <= dlen1_ff;
         slen2_ff  <= slen1_ff;
         lead2_ff  <= lead2_in;
         lead3_ff  <= lead2_ff;
         rem3_ff   <= rem3_in;
         dwl3_ff   <= dwl3_in;
         lead4_ff  <= lead3_ff;
         rem4_ff   <= rem3_ff;
         dwl4_ff   <= dwl3_ff;
         trail4_ff <= trail4_in;
         lead5_ff  <= lead4_ff;
         trail5_ff <= trail4_ff;
         mid_d5_ff <= mid_d5_in;
         mid_s5_ff <= mid_s5_in;
         lead6_ff  <= lead5_ff;
         trail6_ff <= trail5_ff;
         mid_d6_ff <= mid_d5_ff;
         mid_s6_ff <= mid_s5_ff;
         off_d6_ff <= off_d6_in;
         off_s6_ff <= off_s6_in;
      end
   end

   assign pos_d   = dpos_ff[ST-1];
   assign pos_s   = spos_ff[ST-1];
   assign lead    = lead6_ff;
   assign mid_d   = mid_d6_ff;
   assign mid_s   = mid_s6_ff;
   assign trail   = trail6_ff;
   assign off_d   = off_d6_ff;
   assign off_s   = off_s6_ff;
   assign band_ok = {(trail6_ff != '0),
                     (mid_d6_ff != '0) && (mid_s6_ff != '0),
                     (lead6_ff != '0)};
endmodule

[hdl/nss_front.sv]
// nss_front: accepts draws, picks the source rect, and builds a slice plan per draw
// depends on nss_pkg, nss_req_if and nss_axis; plans with no slice are dropped here
module nss_front #(
   parameter int COORD_WIDTH = nss_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   nss_req_if.sink                                  req_if,
   input  logic [nss_pkg::IMAGE_DIM_WIDTH-1:0]      image_width,
   input  logic [nss_pkg::IMAGE_DIM_WIDTH-1:0]      image_height,
   input  logic [COORD_WIDTH-1:0]                   inset_left,
   input  logic [COORD_WIDTH-1:0]                   inset_top,
   input  logic [COORD_WIDTH-1:0]                   inset_right,
   input  logic [COORD_WIDTH-1:0]                   inset_bottom,
   output logic                                     plan_valid,
   input  logic                                     plan_ready,
   output logic [nss_pkg::plan_width(COORD_WIDTH)-1:0] plan_data
);
   localparam int W  = COORD_WIDTH;
   localparam int SW = nss_pkg::span_width(COORD_WIDTH);
   localparam int ST = nss_pkg::FRONT_STAGES;
   localparam int NS = nss_pkg::NUM_SLICES;
   localparam int NC = nss_pkg::NUM_COLS;

   typedef struct packed {
      logic [W-1:0]  pos_d;
      logic [W-1:0]  pos_s;
      logic [SW-1:0] lead;
      logic [SW-1:0] mid_d;
      logic [SW-1:0] mid_s;
      logic [SW-1:0] trail;
      logic [SW:0]   off_d;
      logic [SW:0]   off_s;
   } axis_plan_type;

   typedef struct packed {
      logic [NS-1:0] mask;
      axis_plan_type x;
      axis_plan_type y;
   } plan_type;

   logic [ST-1:0] valid_ff, valid_in;
   logic          en;
   logic          last_valid;

   logic [W-1:0]  sx_pos, sy_pos;
   logic [SW-1:0] sw_len, sh_len;
   logic [SW-1:0] ins_l, ins_t, ins_r, ins_b;
   logic [NC-1:0] x_ok, y_ok;
   logic [NS-1:0] slice_mask;
   plan_type      plan;

   assign last_valid    = valid_ff[ST-1];
   assign en            = !last_valid || plan_ready;
   assign req_if.ready  = en;

   always_comb begin
      valid_in = valid_ff;
      if (en) begin
         valid_in = {valid_ff[ST-2:0], req_if.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // full image spans are whole pixels, shifted into sixteenths
   always_comb begin
      if (req_if.use_source_rect) begin
         sx_pos = req_if.source_x;
         sy_pos = req_if.source_y;
         sw_len = SW'(req_if.source_w);
         sh_len = SW'(req_if.source_h);
      end else begin
         sx_pos = '0;
         sy_pos = '0;
         sw_len = SW'({image_width, {nss_pkg::FRAC_BITS{1'b0}}});
         sh_len = SW'({image_height, {nss_pkg::FRAC_BITS{1'b0}}});
      end
   end

   // negative insets count as zero
   assign ins_l = inset_left[W-1]   ? '0 : SW'(inset_left[W-2:0]);
   assign ins_t = inset_top[W-1]    ? '0 : SW'(inset_top[W-2:0]);
   assign ins_r = inset_right[W-1]  ? '0 : SW'(inset_right[W-2:0]);
   assign ins_b = inset_bottom[W-1] ? '0 : SW'(inset_bottom[W-2:0]);

   nss_axis #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_axis_x (
      .clock     (clock),
      .en        (en),
      .d_pos     (req_if.dest_x),
      .d_len     (SW'(req_if.dest_w)),
      .s_pos     (sx_pos),
      .s_len     (sw_len),
      .lead_ins  (ins_l),
      .trail_ins (ins_r),
      .pos_d     (plan.x.pos_d),
      .pos_s     (plan.x.pos_s),
      .lead      (plan.x.lead),
      .mid_d     (plan.x.mid_d),
      .mid_s     (plan.x.mid_s),
      .trail     (plan.x.trail),
      .off_d     (plan.x.off_d),
      .off_s     (plan.x.off_s),
      .band_ok   (x_ok)
   );

   nss_axis #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_axis_y (
      .clock     (clock),
      .en        (en),
      .d_pos     (req_if.dest_y),
      .d_len     (SW'(req_if.dest_h)),
      .s_pos     (sy_pos),
      .s_len     (sh_len),
      .lead_ins  (ins_t),
      .trail_ins (ins_b),
      .pos_d     (plan.y.pos_d),
      .pos_s     (plan.y.pos_s),
      .lead      (plan.y.lead),
      .mid_d     (plan.y.mid_d),
      .mid_s     (plan.y.mid_s),
      .trail     (plan.y.trail),
      .off_d     (plan.y.off_d),
      .off_s     (plan.y.off_s),
      .band_ok   (y_ok)
   );

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         slice_mask[k] = x_ok[k % NC] && y_ok[k / NC];
      end
   end

   assign plan.mask  = slice_mask;
   assign plan_valid = last_valid && (slice_mask != '0);
   assign plan_data  = plan;
endmodule

[hdl/nss_queue.sv]
// nss_queue: short first-in first-out queue of slice plans between front and back
// depends on nss_pkg for the default depth; storage in flops, head shown ahead
module nss_queue #(
   parameter int WIDTH = nss_pkg::plan_width(nss_pkg::COORD_WIDTH_DEFAULT),
   parameter int DEPTH = nss_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

[hdl/nss_back.sv]
// nss_back: walks each plan's slice mask; one beat per cycle unless rsp_if stalls
// depends on nss_pkg and nss_rsp_if; result register decouples the response side
module nss_back #(
   parameter int COORD_WIDTH = nss_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        plan_valid,
   output logic                                        plan_pop,
   input  logic [nss_pkg::plan_width(COORD_WIDTH)-1:0] plan_data,
   nss_rsp_if.source                                   rsp_if
);
   localparam int W  = COORD_WIDTH;
   localparam int SW = nss_pkg::span_width(COORD_WIDTH);
   localparam int EW = nss_pkg::sum_width(COORD_WIDTH);
   localparam int NS = nss_pkg::NUM_SLICES;
   localparam int NC = nss_pkg::NUM_COLS;
   localparam int IW = nss_pkg::SLICE_IDX_WIDTH;

   typedef struct packed {
      logic [W-1:0]  pos_d;
      logic [W-1:0]  pos_s;
      logic [SW-1:0] lead;
      logic [SW-1:0] mid_d;
      logic [SW-1:0] mid_s;
      logic [SW-1:0] trail;
      logic [SW:0]   off_d;
      logic [SW:0]   off_s;
   } axis_plan_type;

   typedef struct packed {
      logic [NS-1:0] mask;
      axis_plan_type x;
      axis_plan_type y;
   } plan_type;

   plan_type      head;
   plan_type      plan_ff, plan_in;
   logic [NS-1:0] rem_ff, rem_in;
   logic          busy, out_adv, load, last;
   logic [NS-1:0] pick;
   logic [NS-1:0] rem_left;
   logic [IW-1:0] pick_idx;
   logic [1:0]    pick_col, pick_row;

   logic [SW:0]   xo_d, xo_s, yo_d, yo_s;
   logic [SW-1:0] xs_d, xs_s, ys_d, ys_s;
   logic [EW-1:0] sum_dx, sum_dy, sum_sx, sum_sy;
   logic [SW:0]   wid_dx, wid_dy, wid_sx, wid_sy;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] idx_ff;
   logic [W+1:0]  dst_x_ff, dst_y_ff, src_x_ff, src_y_ff;
   logic [W-1:0]  dst_w_ff, dst_h_ff, src_w_ff, src_h_ff;
   logic          last_ff;

   assign head     = plan_type'(plan_data);
   assign busy     = (rem_ff != '0);
   assign out_adv  = !rsp_valid_ff || rsp_if.ready;

   // lowest pending slice first
   always_comb begin
      pick     = '0;
      pick_idx = '0;
      pick_col = '0;
      pick_row = '0;
      for (int i = NS - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            pick     = '0;
            pick[i]  = 1'b1;
            pick_idx = IW'(i);
            pick_col = 2'(i % NC);
            pick_row = 2'(i / NC);
         end
      end
   end

   assign rem_left = rem_ff & ~pick;
   assign last     = (rem_left == '0);
   assign load     = plan_valid && (!busy || (out_adv && last));
   assign plan_pop = load;

   always_comb begin
      rem_in  = rem_ff;
      plan_in = plan_ff;
      if (out_adv && busy) begin
         rem_in = rem_left;
      end
      if (load) begin
         rem_in  = head.mask;
         plan_in = head;
      end
   end

   always_comb begin
      case (pick_col)
         2'd0: begin
            xo_d = '0;
            xo_s = '0;
            xs_d = plan_ff.x.lead;
            xs_s = plan_ff.x.lead;
         end
         2'd1: begin
            xo_d = (SW+1)'(plan_ff.x.lead);
            xo_s = (SW+1)'(plan_ff.x.lead);
            xs_d = plan_ff.x.mid_d;
            xs_s = plan_ff.x.mid_s;
         end
         default: begin
            xo_d = plan_ff.x.off_d;
            xo_s = plan_ff.x.off_s;
            xs_d = plan_ff.x.trail;
            xs_s = plan_ff.x.trail;
         end
      endcase
      case (pick_row)
         2'd0: begin
            yo_d = '0;
            yo_s = '0;
            ys_d = plan_ff.y.lead;
            ys_s = plan_ff.y.lead;
         end
         2'd1: begin
            yo_d = (SW+1)'(plan_ff.y.lead);
            yo_s = (SW+1)'(plan_ff.y.lead);
            ys_d = plan_ff.y.mid_d;
            ys_s = plan_ff.y.mid_s;
         end
         default: begin
            yo_d = plan_ff.y.off_d;
            yo_s = plan_ff.y.off_s;
            ys_d = plan_ff.y.trail;
            ys_s = plan_ff.y.trail;
         end
      endcase
   end

   assign sum_dx = EW'($signed(plan_ff.x.pos_d)) + EW'(xo_d);
   assign sum_dy = EW'($signed(plan_ff.y.pos_d)) + EW'(yo_d);
   assign sum_sx = EW'($signed(plan_ff.x.pos_s)) + EW'(xo_s);
   assign sum_sy = EW'($signed(plan_ff.y.pos_s)) + EW'(yo_s);
   assign wid_dx = (SW+1)'(xs_d);
   assign wid_dy = (SW+1)'(ys_d);
   assign wid_sx = (SW+1)'(xs_s);
   assign wid_sy = (SW+1)'(ys_s);

   assign rsp_valid_in = out_adv ? busy : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      if (out_adv && busy) begin
         idx_ff   <= pick_idx;
         dst_x_ff <= sum_dx[W+1:0];
         dst_y_ff <= sum_dy[W+1:0];
         src_x_ff <= sum_sx[W+1:0];
         src_y_ff <= sum_sy[W+1:0];
         dst_w_ff <= wid_dx[W-1:0];
         dst_h_ff <= wid_dy[W-1:0];
         src_w_ff <= wid_sx[W-1:0];
         src_h_ff <= wid_sy[W-1:0];
         last_ff  <= last;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.slice_index = idx_ff;
   assign rsp_if.out_dst_x   = dst_x_ff;
   assign rsp_if.out_dst_y   = dst_y_ff;
   assign rsp_if.out_dst_w   = dst_w_ff;
   assign rsp_if.out_dst_h   = dst_h_ff;
   assign rsp_if.out_src_x   = src_x_ff;
   assign rsp_if.out_src_y   = src_y_ff;
   assign rsp_if.out_src_w   = src_w_ff;
   assign rsp_if.out_src_h   = src_h_ff;
   assign rsp_if.last_slice  = last_ff;
endmodule

[hdl/nine_slice_splitter.sv]
// nine_slice_splitter: top level with register file, plan front end, queue and slice back end
// depends on nss_pkg, nss_req_if, nss_rsp_if, nss_front, nss_queue and nss_back
//
// Each request beat describes one draw; the block answers with one response beat per
// non-empty slice, in row-major order, with last_slice set on the final one. A draw
// that leaves nothing to draw gives no beat at all. The back end issues one slice
// per cycle while the response side takes its beats, and a draw gives one to nine
// slices; the six-stage front end and a two-entry plan queue let the next draws be
// taken in while slices are still going out. The first slice of a draw passes the
// front end stages, the queue, and the plan and result registers of the back end.
// Registers are written through the APB-style port (4-byte spacing, always ready)
// and must only change while no draw is in flight.
module nine_slice_splitter #(
   parameter int COORD_WIDTH = nss_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   nss_req_if.sink                             req_if,
   nss_rsp_if.source                           rsp_if,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [nss_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [nss_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [nss_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);
   localparam int W  = COORD_WIDTH;
   localparam int DW = nss_pkg::CSR_DATA_WIDTH;
   localparam int IMW = nss_pkg::IMAGE_DIM_WIDTH;
   localparam int PW = nss_pkg::plan_width(COORD_WIDTH);

   logic [IMW-1:0] image_width_ff, image_width_in;
   logic [IMW-1:0] image_height_ff, image_height_in;
   logic [W-1:0]   inset_left_ff, inset_left_in;
   logic [W-1:0]   inset_top_ff, inset_top_in;
   logic [W-1:0]   inset_right_ff, inset_right_in;
   logic [W-1:0]   inset_bottom_ff, inset_bottom_in;

   logic                  csr_wr;
   nss_pkg::reg_index_type csr_index;

   logic          fq_valid, fq_ready;
   logic [PW-1:0] fq_data;
   logic          qb_valid, qb_pop;
   logic [PW-1:0] qb_data;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = nss_pkg::reg_index_type'(
                         paddr[nss_pkg::CSR_ADDR_WIDTH-1:nss_pkg::CSR_INDEX_LSB]);

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      inset_left_in   = inset_left_ff;
      inset_top_in    = inset_top_ff;
      inset_right_in  = inset_right_ff;
      inset_bottom_in = inset_bottom_ff;
      if (csr_wr) begin
         unique case (csr_index)
            nss_pkg::REG_IMAGE_WIDTH:  image_width_in  = pwdata[IMW-1:0];
            nss_pkg::REG_IMAGE_HEIGHT: image_height_in = pwdata[IMW-1:0];
            nss_pkg::REG_INSET_LEFT:   inset_left_in   = pwdata[W-1:0];
            nss_pkg::REG_INSET_TOP:    inset_top_in    = pwdata[W-1:0];
            nss_pkg::REG_INSET_RIGHT:  inset_right_in  = pwdata[W-1:0];
            nss_pkg::REG_INSET_BOTTOM: inset_bottom_in = pwdata[W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= '0;
         image_height_ff <= '0;
         inset_left_ff   <= '0;
         inset_top_ff    <= '0;
         inset_right_ff  <= '0;
         inset_bottom_ff <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         inset_left_ff   <= inset_left_in;
         inset_top_ff    <= inset_top_in;
         inset_right_ff  <= inset_right_in;
         inset_bottom_ff <= inset_bottom_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         nss_pkg::REG_IMAGE_WIDTH:  prdata = DW'(image_width_ff);
         nss_pkg::REG_IMAGE_HEIGHT: prdata = DW'(image_height_ff);
         nss_pkg::REG_INSET_LEFT:   prdata = DW'(inset_left_ff);
         nss_pkg::REG_INSET_TOP:    prdata = DW'(inset_top_ff);
         nss_pkg::REG_INSET_RIGHT:  prdata = DW'(inset_right_ff);
         nss_pkg::REG_INSET_BOTTOM: prdata = DW'(inset_bottom_ff);
         default:                   prdata = '0;
      endcase
   end

   nss_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .inset_left   (inset_left_ff),
      .inset_top    (inset_top_ff),
      .inset_right  (inset_right_ff),
      .inset_bottom (inset_bottom_ff),
      .plan_valid   (fq_valid),
      .plan_ready   (fq_ready),
      .plan_data    (fq_data)
   );

   nss_queue #(
      .WIDTH (PW),
      .DEPTH (nss_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_pop),
      .pop_data   (qb_data)
   );

   nss_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .plan_valid (qb_valid),
      .plan_pop   (qb_pop),
      .plan_data  (qb_data),
      .rsp_if     (rsp_if)
   );
endmodule
